// File: design/smws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smws_pkg
// Shared types and constants of the SPI master word shifter.
// ----------------------------------------------------------------------------
package smws_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned BITS_W      = 6;
	localparam int unsigned HP_W        = 16;
	localparam int unsigned MODE_W      = 2;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned DEF_MAX_WORD_BITS = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SPI_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PER  = 2'd2;

	localparam logic [MODE_W-1:0] RST_SPI_MODE  = 2'd0;
	localparam logic [BITS_W-1:0] RST_WORD_BITS = 6'd8;
	localparam logic [HP_W-1:0]   RST_HALF_PER  = 16'd1;

	localparam int unsigned S_DATA_W = 40;
	localparam int unsigned M_DATA_W = 40;

	typedef struct packed {
		logic [MODE_W-1:0] spi_mode;
		logic [BITS_W-1:0] word_bits;
		logic [HP_W-1:0]   half_period_ticks;
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] rx_word;
		logic              done_res;
		logic              busy_res;
		logic              mosi;
		logic              sclk;
	} result_t;

endpackage

// File: design/smws_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smws_core
// Transfer state of the SPI master: shift register, bit count, half-period
// counter and line levels, advanced by one system tick per item.
// ----------------------------------------------------------------------------
module smws_core import smws_pkg::*; #(
	parameter int unsigned MAX_WORD_BITS = DEF_MAX_WORD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  cfg_t              cfg,
	input  logic              start_req,
	input  logic [WORD_W-1:0] tx_word,
	input  logic              miso,
	output result_t           res
);

	localparam logic [BITS_W-1:0] MAX_BITS = BITS_W'(MAX_WORD_BITS);

	logic [WORD_W-1:0] shift_q, shift_d;
	logic [BITS_W-1:0] bits_left_q, bits_left_d;
	logic [HP_W-1:0]   tick_q, tick_d;
	logic              phase_q, phase_d;
	logic              clk_lvl_q, clk_lvl_d;
	logic              dout_q, dout_d;
	logic              active_q, active_d;

	logic              cpol, cpha;
	logic [HP_W-1:0]   hp;
	logic [BITS_W-1:0] n_bits;
	logic [HP_W-1:0]   tick_inc;
	logic [WORD_W-1:0] shift_in;
	logic [BITS_W-1:0] bits_dec;
	logic              done;

	always_comb begin
		cpol = cfg.spi_mode[1];
		cpha = cfg.spi_mode[0];
		hp = (cfg.half_period_ticks == '0) ? HP_W'(1) : cfg.half_period_ticks;
		if (cfg.word_bits == '0) begin
			n_bits = BITS_W'(1);
		end else if (cfg.word_bits > MAX_BITS) begin
			n_bits = MAX_BITS;
		end else begin
			n_bits = cfg.word_bits;
		end
		tick_inc = tick_q + HP_W'(1);
		shift_in = {shift_q[WORD_W-2:0], miso};
		bits_dec = bits_left_q - BITS_W'(1);

		shift_d     = shift_q;
		bits_left_d = bits_left_q;
		tick_d      = tick_q;
		phase_d     = phase_q;
		clk_lvl_d   = clk_lvl_q;
		dout_d      = dout_q;
		active_d    = active_q;
		done        = 1'b0;

		if (!active_q) begin
			if (start_req) begin
				shift_d     = tx_word << (BITS_W'(WORD_W) - n_bits);
				bits_left_d = n_bits;
				tick_d      = '0;
				phase_d     = 1'b0;
				clk_lvl_d   = cpol;
				active_d    = 1'b1;
				if (!cpha) begin
					dout_d = shift_d[WORD_W-1];
				end
			end
		end else begin
			tick_d = tick_inc;
			if (tick_inc >= hp) begin
				tick_d = '0;
				if (!phase_q) begin
					clk_lvl_d = ~cpol;
					if (cpha) begin
						dout_d = shift_q[WORD_W-1];
					end
					phase_d = 1'b1;
				end else begin
					shift_d     = shift_in;
					bits_left_d = bits_dec;
					clk_lvl_d   = cpol;
					phase_d     = 1'b0;
					if (bits_dec == '0) begin
						active_d = 1'b0;
						done     = 1'b1;
					end else if (!cpha) begin
						dout_d = shift_in[WORD_W-1];
					end
				end
			end
		end

		res.sclk     = active_d ? clk_lvl_d : cpol;
		res.mosi     = dout_d;
		res.busy_res = active_d;
		res.done_res = done;
		res.rx_word  = done ? shift_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= '0;
			bits_left_q <= '0;
			tick_q      <= '0;
			phase_q     <= 1'b0;
			clk_lvl_q   <= 1'b0;
			dout_q      <= 1'b0;
			active_q    <= 1'b0;
		end else if (step_en) begin
			shift_q     <= shift_d;
			bits_left_q <= bits_left_d;
			tick_q      <= tick_d;
			phase_q     <= phase_d;
			clk_lvl_q   <= clk_lvl_d;
			dout_q      <= dout_d;
			active_q    <= active_d;
		end
	end

endmodule

// File: design/spi_master_word_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_word_shifter
// Full-duplex SPI master, modes 0 to 3, MSB first, one word per transfer.
// ----------------------------------------------------------------------------
// Each input item is one system tick and yields exactly one result item with
// the SCLK and MOSI levels, busy, done and the received word (nonzero only on
// the done item). One item is accepted per cycle; the result is held in an
// output register, so the input side keeps moving while a result waits as
// long as the downstream side takes it in the same cycle. Configuration
// registers: 0 spi_mode (bit1 CPOL, bit0 CPHA), 1 word_bits (saturates to
// MAX_WORD_BITS, zero means 1), 2 half_period_ticks (zero means 1).
module spi_master_word_shifter import smws_pkg::*; #(
	parameter int unsigned MAX_WORD_BITS = DEF_MAX_WORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,    // start_req, tx_word[31:0], miso, zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,    // sclk, mosi, busy_res, done_res, rx_word[31:0], zero pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    step_en;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign step_en   = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(M_DATA_W - $bits(result_t)){1'b0}}, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spi_mode          <= RST_SPI_MODE;
			cfg_q.word_bits         <= RST_WORD_BITS;
			cfg_q.half_period_ticks <= RST_HALF_PER;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SPI_MODE:  cfg_q.spi_mode <= cfg_data[MODE_W-1:0];
				REG_WORD_BITS: cfg_q.word_bits <= cfg_data[BITS_W-1:0];
				REG_HALF_PER:  cfg_q.half_period_ticks <= cfg_data[HP_W-1:0];
				default: ;
			endcase
		end
	end

	smws_core #(
		.MAX_WORD_BITS(MAX_WORD_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.cfg       (cfg_q),
		.start_req (s_tdata[0]),
		.tx_word   (s_tdata[WORD_W:1]),
		.miso      (s_tdata[WORD_W+1]),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res;
		end
	end

endmodule
